// ===== hw/rtl/dcs_pkg.sv =====
// Shared types and constants for the distributed-clock PI phase lock.
// Used by dcs_mul and dc_clock_sync_pi; depends on nothing.
package dcs_pkg;

	// integral accumulator width (valid range 32..64)
	localparam int INTEGRAL_WIDTH = 48;

	// register file
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TIME   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P_GAIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP_COUNT = 3'd4;

	localparam logic [29:0] SYNC_OFFSET_RST  = 30'd500000;
	localparam logic [29:0] CYCLE_TIME_RST   = 30'd1000000;
	localparam logic [31:0] P_GAIN_RST       = 32'd42949673;
	localparam logic [31:0] I_GAIN_RST       = 32'd85899;
	localparam logic [31:0] WARMUP_COUNT_RST = 32'd2000;

	// stream payload widths
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 160;

	// restoring remainder: one dividend bit per cycle
	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// integral product magnitude limit, beyond any 32-bit result
	localparam logic [40:0] MUL_CLAMP = 41'h100_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_INTEG,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

endpackage

// ===== hw/rtl/dcs_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
// Depends on dcs_pkg (mul_req_t).
module dcs_mul (
	input  logic              clk,
	input  dcs_pkg::mul_req_t req,
	output logic [63:0]       prod_q
);
	import dcs_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= 64'(req.a) * 64'(req.b);
	end

endmodule

// ===== hw/rtl/dc_clock_sync_pi.sv =====
// PI phase lock for a distributed-clock cycle: remainder, integral, statistics, correction.
// Sequence per input beat: accept, 64 remainder steps, fix, integral, two multiply steps, sum,
// output load; m_tvalid is registered from the output load.
// A new beat is accepted only once the previous result is loaded; a held result stalls the last
// step. One shared multiplier serves the P term and both integral halves.
// Reset (arst_n low, async): default registers, integral and statistics clear; depends on dcs_pkg.
module dc_clock_sync_pi (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [dcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dcs_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dcs_pkg::IN_TDATA_W-1:0]      s_tdata,  // ref_time[62:0], cycle_count[94:63], pad
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dcs_pkg::OUT_TDATA_W-1:0]     m_tdata   // offset_ns[31:0], phase_error[62:32],
	                                                       // max_abs_error[92:63],
	                                                       // abs_error_sum[155:93], pad
);
	import dcs_pkg::*;

	localparam int IW = INTEGRAL_WIDTH;

	// config registers
	logic [29:0] sync_offset_q;
	logic [29:0] cycle_time_q;
	logic [31:0] p_gain_q;
	logic [31:0] i_gain_q;
	logic [31:0] warmup_count_q;

	// sequencer and work registers
	state_t                 state_q, state_d;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic                   sign_q;      // dividend negative
	logic [63:0]            mag_q;       // dividend magnitude, shifted out MSB first
	logic [29:0]            rem_q;
	logic [31:0]            count_q;
	logic signed [30:0]     err_q;
	logic signed [31:0]     pterm_q;
	logic [31:0]            lo_term_q;
	logic [40:0]            iterm_mag_q;

	// persistent state
	logic signed [IW-1:0]   integral_q;
	logic [29:0]            peak_q;
	logic [62:0]            total_q;

	// result register
	logic                   out_valid_q;
	logic signed [31:0]     out_offset_q;
	logic signed [30:0]     out_error_q;
	logic [29:0]            out_peak_q;
	logic [62:0]            out_total_q;

	// shared multiplier
	mul_req_t    mul_req;
	logic [63:0] mul_prod;

	dcs_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (mul_prod)
	);

	logic in_beat, out_free;
	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// ---- combinational datapath ----
	// dividend = ref_time - sync_offset, always fits signed 64
	logic [63:0] dividend;
	logic [63:0] dividend_mag;
	assign dividend     = 64'(s_tdata[62:0]) - 64'(sync_offset_q);
	assign dividend_mag = dividend[63] ? (~dividend + 64'd1) : dividend;

	// one restoring step
	logic [30:0] rem_trial, rem_step;
	assign rem_trial = {rem_q, mag_q[63]};
	assign rem_step  = (rem_trial >= {1'b0, cycle_time_q}) ?
		(rem_trial - {1'b0, cycle_time_q}) : rem_trial;

	// signed remainder, wrap above half a cycle, negate
	logic signed [31:0] rem_s, delta_a, delta_b, half_s, ct_s, err_full;
	always_comb begin
		rem_s    = $signed({2'b00, rem_q});
		half_s   = $signed({3'b000, cycle_time_q[29:1]});
		ct_s     = $signed({2'b00, cycle_time_q});
		delta_a  = sign_q ? -rem_s : rem_s;
		delta_b  = (delta_a > half_s) ? (delta_a - ct_s) : delta_a;
		err_full = (cycle_time_q == '0) ? 32'sd0 : -delta_b;
	end

	// saturating integral update
	logic signed [IW:0]   integ_sum;
	logic signed [IW-1:0] integ_next;
	always_comb begin
		integ_sum = (IW+1)'(integral_q) + (IW+1)'(err_q);
		if (integ_sum[IW] != integ_sum[IW-1])
			integ_next = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		else
			integ_next = integ_sum[IW-1:0];
	end

	// statistics
	logic [30:0] abs_full;
	logic [29:0] abs_err;
	logic [63:0] total_sum;
	assign abs_full  = err_q[30] ? 31'(-err_q) : 31'(err_q);
	assign abs_err   = abs_full[29:0];
	assign total_sum = 64'(total_q) + 64'(abs_err);

	// integral magnitude split into two 32-bit halves
	logic [IW-1:0] imag;
	logic [63:0]   imag64;
	assign imag   = integral_q[IW-1] ? IW'(-integral_q) : IW'(integral_q);
	assign imag64 = 64'(imag);

	// integral product: hi*g + (lo*g >> 32), clamped
	logic [64:0] iterm_sum;
	assign iterm_sum = 65'(mul_prod) + 65'(lo_term_q);

	// final correction, saturated to 32-bit signed
	logic signed [41:0] iterm_s, corr;
	logic signed [31:0] corr_sat;
	always_comb begin
		iterm_s = integral_q[IW-1] ? -$signed({1'b0, iterm_mag_q}) : $signed({1'b0, iterm_mag_q});
		corr    = iterm_s + 42'(pterm_q);
		if (corr > 42'sd2147483647)
			corr_sat = 32'sh7FFF_FFFF;
		else if (corr < -42'sd2147483648)
			corr_sat = 32'sh8000_0000;
		else
			corr_sat = corr[31:0];
	end

	// ---- sequencer: next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_beat) state_d = ST_DIV;
			ST_DIV:    if (div_cnt_q == '0) state_d = ST_FIX;
			ST_FIX:    state_d = ST_INTEG;
			ST_INTEG:  state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_SUM;
			ST_SUM:    state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// ---- sequencer: outputs ----
	always_comb begin
		s_tready  = 1'b0;
		mul_req.a = 32'(abs_err);
		mul_req.b = p_gain_q;
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_INTEG:  begin
				mul_req.a = 32'(abs_err);
				mul_req.b = p_gain_q;
			end
			ST_MUL_LO: begin
				mul_req.a = imag64[31:0];
				mul_req.b = i_gain_q;
			end
			ST_MUL_HI: begin
				mul_req.a = imag64[63:32];
				mul_req.b = i_gain_q;
			end
			default:   ;
		endcase
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sync_offset_q  <= SYNC_OFFSET_RST;
			cycle_time_q   <= CYCLE_TIME_RST;
			p_gain_q       <= P_GAIN_RST;
			i_gain_q       <= I_GAIN_RST;
			warmup_count_q <= WARMUP_COUNT_RST;
			integral_q     <= '0;
			peak_q         <= '0;
			total_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_SYNC_OFFSET:  sync_offset_q  <= cfg_data[29:0];
					REG_CYCLE_TIME:   cycle_time_q   <= cfg_data[29:0];
					REG_P_GAIN:       p_gain_q       <= cfg_data;
					REG_I_GAIN:       i_gain_q       <= cfg_data;
					REG_WARMUP_COUNT: warmup_count_q <= cfg_data;
					default:          ;
				endcase
			end
			if (state_q == ST_INTEG) begin
				integral_q <= integ_next;
				if (count_q > warmup_count_q) begin
					if (abs_err > peak_q)
						peak_q <= abs_err;
					total_q <= total_sum[63] ? {63{1'b1}} : total_sum[62:0];
				end
			end
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sign_q    <= dividend[63];
				mag_q     <= dividend_mag;
				count_q   <= s_tdata[94:63];
				rem_q     <= '0;
				div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
			end
			ST_DIV: begin
				rem_q     <= rem_step[29:0];
				mag_q     <= {mag_q[62:0], 1'b0};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			ST_FIX:    err_q <= err_full[30:0];
			ST_MUL_LO: pterm_q <= err_q[30] ? -$signed({2'b00, mul_prod[61:32]})
			                                :  $signed({2'b00, mul_prod[61:32]});
			ST_MUL_HI: lo_term_q <= mul_prod[63:32];
			ST_SUM:    iterm_mag_q <= (iterm_sum > 65'(MUL_CLAMP)) ? MUL_CLAMP : iterm_sum[40:0];
			ST_DONE: begin
				if (out_free) begin
					out_offset_q <= corr_sat;
					out_error_q  <= err_q;
					out_peak_q   <= peak_q;
					out_total_q  <= total_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_total_q, out_peak_q, out_error_q, out_offset_q};

`ifndef SYNTHESIS
	// one beat in flight: no second accept right after a first
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("input accepted while item in flight");

	// a result appears only out of the final sequencer step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside final step");

	// remainder loop ends after its last step
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == '0) |=> state_q == ST_FIX)
		else $error("remainder loop did not terminate");
`endif

endmodule
